// ===== design/wcas_pkg.sv =====
package wcas_pkg;

    // block configuration
    localparam int WINDOW     = 60;
    localparam int COUNT_BITS = 16;

    // field widths
    localparam int SNAP_W     = 48;
    localparam int COUNT_W    = 16;
    localparam int FACTOR_W   = 16;
    localparam int DELTA_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // derived widths
    localparam int SUM_W     = DELTA_W + $clog2(WINDOW);
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int DIV_CNT_W = $clog2(SUM_W);
    localparam int PROD_W    = COUNT_W + FACTOR_W;
    localparam int AN_W      = COUNT_W + FILL_W;

    // constants
    localparam logic [COUNT_W-1:0] WORKER_LIMIT = (COUNT_BITS >= COUNT_W) ? '1 :
        COUNT_W'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [COUNT_W-1:0]  IDLE_FLOOR  = COUNT_W'(10);
    localparam logic [FACTOR_W-1:0] UP_RESET    = FACTOR_W'(512);
    localparam logic [FACTOR_W-1:0] DOWN_RESET  = FACTOR_W'(128);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_UP   = 2'd0,
        CFG_SCALE_DOWN = 2'd1
    } t_cfg_idx;

    // channel payloads
    typedef struct packed {
        logic [SNAP_W-1:0]  total_ops_snapshot;
        logic [COUNT_W-1:0] active_count;
    } t_in_beat;

    typedef struct packed {
        logic [COUNT_W-1:0] target_count;
        logic               target_changed;
        logic [COUNT_W-1:0] spawn_count;
    } t_out_beat;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_PREP,
        S_DIV,
        S_DECIDE,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic update;
        logic prep;
        logic div_step;
        logic decide;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_status;

endpackage

// ===== design/wcas_in_if.sv =====
interface wcas_in_if;
    import wcas_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/wcas_out_if.sv =====
interface wcas_out_if;
    import wcas_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/wcas_ram.sv =====
module wcas_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/wcas_ctrl.sv =====
module wcas_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  wcas_pkg::t_status i_status,
    output wcas_pkg::t_cmd   o_cmd
);
    import wcas_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_PREP;
            S_PREP:   n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: n_state = S_DONE;
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_UPDATE: o_cmd.update   = 1'b1;
            S_PREP:   o_cmd.prep     = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_DECIDE: o_cmd.decide   = 1'b1;
            S_DONE:   o_cmd.emit     = i_status.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/wcas_datapath.sv =====
module wcas_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wcas_pkg::t_cmd                   i_cmd,
    output wcas_pkg::t_status                o_status,
    input  wcas_pkg::t_in_beat               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output wcas_pkg::t_out_beat              o_out_data,
    input  logic                             i_cfg_we,
    input  logic [wcas_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wcas_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wcas_pkg::*;

    logic [FACTOR_W-1:0] r_up_factor;
    logic [FACTOR_W-1:0] r_down_factor;
    logic [SNAP_W-1:0]   r_prev_total;
    logic [DELTA_W-1:0]  r_delta;
    logic [COUNT_W-1:0]  r_active;
    logic [SUM_W-1:0]    r_sum;
    logic [FILL_W-1:0]   r_fill;
    logic [PTR_W-1:0]    r_ptr;
    logic [COUNT_W-1:0]  r_target;
    logic [COUNT_W-1:0]  r_desired;
    logic [AN_W-1:0]     r_prod_an;
    logic [SUM_W+1:0]    r_sum3;
    logic [PROD_W-1:0]   r_prod_up;
    logic [PROD_W-1:0]   r_prod_dn;
    logic [SUM_W-1:0]    r_quo;
    logic [FILL_W-1:0]   r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                r_lt_one;
    logic                r_go_up;
    logic                r_go_dn;
    logic                r_out_valid;
    t_out_beat           r_out_data;

    logic [SNAP_W-1:0]   n_delta_full;
    logic [DELTA_W-1:0]  n_delta;
    logic [DELTA_W-1:0]  ram_rdata;
    logic                win_full;
    logic [SUM_W-1:0]    n_sum_base;
    logic [FILL_W:0]     rem_shift;
    logic                div_ge;
    logic [FILL_W:0]     rem_sub;
    logic [PROD_W:0]     sc_up_full;
    logic [PROD_W:0]     sc_dn_full;
    logic [SUM_W-1:0]    sc_up;
    logic [SUM_W-1:0]    sc_dn;
    logic [SUM_W-1:0]    cand;
    logic [COUNT_W-1:0]  n_desired;
    logic                n_changed;
    logic [COUNT_W-1:0]  n_spawn;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_factor   <= UP_RESET;
            r_down_factor <= DOWN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCALE_UP:   r_up_factor   <= i_cfg_data[FACTOR_W-1:0];
                CFG_SCALE_DOWN: r_down_factor <= i_cfg_data[FACTOR_W-1:0];
                default: begin
                    r_up_factor <= r_up_factor;
                end
            endcase
        end
    end

    // counter delta, saturated to the window sample width
    always_comb begin
        n_delta_full = i_in_data.total_ops_snapshot - r_prev_total;
        n_delta = (|n_delta_full[SNAP_W-1:DELTA_W]) ? '1 : n_delta_full[DELTA_W-1:0];
    end

    // delta window storage
    wcas_ram #(
        .WIDTH (DELTA_W),
        .DEPTH (WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (r_ptr),
        .i_wdata (r_delta),
        .i_re    (i_cmd.load),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    assign win_full   = (r_fill == FILL_W'(WINDOW));
    assign n_sum_base = win_full ? (r_sum - SUM_W'(ram_rdata)) : r_sum;

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_total <= '0;
            r_sum        <= '0;
            r_fill       <= '0;
            r_ptr        <= '0;
        end else begin
            if (i_cmd.load) begin
                r_prev_total <= i_in_data.total_ops_snapshot;
            end
            if (i_cmd.update) begin
                r_sum <= n_sum_base + SUM_W'(r_delta);
                r_ptr <= (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + PTR_W'(1);
                if (!win_full) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
        end
    end

    // beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_delta  <= n_delta;
            r_active <= i_in_data.active_count;
        end
    end

    // products and divider setup
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_prod_an <= AN_W'(r_active) * AN_W'(r_fill);
            r_sum3    <= (SUM_W+2)'(r_sum) + {1'b0, r_sum, 1'b0};
            r_prod_up <= PROD_W'(r_active) * PROD_W'(r_up_factor);
            r_prod_dn <= PROD_W'(r_active) * PROD_W'(r_down_factor);
        end
    end

    // restoring divider step
    always_comb begin
        rem_shift = {r_rem, r_quo[SUM_W-1]};
        div_ge    = (rem_shift >= {1'b0, r_fill});
        rem_sub   = rem_shift - {1'b0, r_fill};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_quo     <= r_sum + SUM_W'(r_fill) - SUM_W'(1);
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo     <= {r_quo[SUM_W-2:0], div_ge};
            r_rem     <= div_ge ? rem_sub[FILL_W-1:0] : rem_shift[FILL_W-1:0];
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    // mean comparisons, held stable across the divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step) begin
            r_lt_one <= (r_sum < SUM_W'(r_fill));
            r_go_up  <= (SUM_W'(r_prod_an) < r_sum);
            r_go_dn  <= ({(SUM_W+1-AN_W)'(0), r_prod_an, 1'b0} > r_sum3);
        end
    end

    // target selection and clamp
    always_comb begin
        sc_up_full = {1'b0, r_prod_up} + (PROD_W+1)'(255);
        sc_dn_full = {1'b0, r_prod_dn} + (PROD_W+1)'(255);
        sc_up      = SUM_W'(sc_up_full[PROD_W:8]);
        sc_dn      = SUM_W'(sc_dn_full[PROD_W:8]);
        if (r_lt_one) begin
            cand = (r_active > IDLE_FLOOR) ? SUM_W'(r_active) : SUM_W'(IDLE_FLOOR);
        end else if (r_go_up) begin
            cand = (sc_up > r_quo) ? sc_up : r_quo;
        end else if (r_go_dn) begin
            cand = (sc_dn > r_quo) ? sc_dn : r_quo;
        end else begin
            cand = SUM_W'(r_active);
        end
        if (cand > SUM_W'(WORKER_LIMIT)) begin
            n_desired = WORKER_LIMIT;
        end else if (cand == '0) begin
            n_desired = COUNT_W'(1);
        end else begin
            n_desired = cand[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_desired <= n_desired;
        end
    end

    // result fields
    always_comb begin
        n_changed = (r_desired != r_target);
        n_spawn   = (n_changed && (r_active < r_desired)) ? (r_desired - r_active) : '0;
    end

    // current target and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= COUNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_target    <= r_desired;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data.target_count   <= r_desired;
            r_out_data.target_changed <= n_changed;
            r_out_data.spawn_count    <= n_spawn;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_status.div_last = (r_div_cnt == DIV_CNT_W'(SUM_W - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW))
        else $error("window fill beyond window size");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_W'(WINDOW - 1))
        else $error("window pointer out of range");

    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_target != '0) && (r_target <= WORKER_LIMIT))
        else $error("current target outside 1 to limit");

    a_emit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid && (r_out_data.target_count == r_target))
        else $error("emitted beat does not match new target");
`endif

endmodule

// ===== design/worker_count_autoscaler_unit.sv =====
// channel  dir  payload                               handshake
// i_in     in   total_ops_snapshot, active_count      valid / ready
// o_out    out  target_count, target_changed, spawn   valid / ready
// i_cfg    in   i_cfg_index, i_cfg_data               i_cfg_we, no wait
//
// an accepted tick runs through update, prep, the 38-step serial
// divider that forms ceil(mean), decide and done before the next
// accept; done registers the result once the output register is free
// the next tick is taken while a finished result waits in the output register
// reset is synchronous, active low; the delta window needs no clearing pass

module worker_count_autoscaler_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    wcas_in_if.sink                         i_in,
    wcas_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [wcas_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wcas_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wcas_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    // sequencer
    wcas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // window, divider and target logic
    wcas_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    assign i_in.ready = in_ready;

endmodule

// ===== tb/wcas_checker.sv =====
module wcas_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    wcas_in_if                                      i_in_ch,
    wcas_out_if                                     i_out_ch,
    input  logic                                    i_cfg_we,
    input  logic [wcas_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [wcas_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    output int                                      o_fail_count,
    output int                                      o_waiting_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import wcas_pkg::*;

    localparam int          MAX_REPORTS  = 10;
    localparam logic [63:0] SNAP_MASK    = (64'd1 << SNAP_W) - 64'd1;
    localparam logic [63:0] DELTA_CAP    = (64'd1 << DELTA_W) - 64'd1;
    localparam logic [63:0] IDLE_WORKERS = 64'd10;
    localparam logic [63:0] WORKER_CAP   = (COUNT_BITS >= 16) ? 64'd65535 :
        (64'd1 << COUNT_BITS) - 64'd1;

    // scaling factors as last written
    logic [FACTOR_W-1:0] up_factor;
    logic [FACTOR_W-1:0] down_factor;

    // rolling rate history
    logic [SNAP_W-1:0]  last_snapshot;
    logic [DELTA_W-1:0] rate_history [WINDOW];
    logic [63:0]        rate_sum;
    int unsigned        history_fill;
    int unsigned        history_slot;
    logic [COUNT_W-1:0] held_target;

    t_out_beat pending_targets [$];
    int        fail_count;
    int        queued_count;

    assign o_fail_count      = fail_count;
    assign o_waiting_results = queued_count;

    initial begin
        fail_count   = 0;
        queued_count = 0;
    end

    function automatic logic [63:0] larger_of(input logic [63:0] a, input logic [63:0] b);
        return (a > b) ? a : b;
    endfunction

    // ceil(active * factor) with the factor in q8.8
    function automatic logic [63:0] scale_q8(input logic [63:0] act,
                                             input logic [FACTOR_W-1:0] factor);
        return (act * 64'(factor) + 64'd255) >> 8;
    endfunction

    // one scaling tick: update the history, then pick the new target
    task automatic predict_target(input t_in_beat tick, output t_out_beat res);
        logic [63:0] delta;
        logic [63:0] fill;
        logic [63:0] sum;
        logic [63:0] act;
        logic [63:0] mean_ceil;
        logic [63:0] want;

        delta = (64'(tick.total_ops_snapshot) - 64'(last_snapshot)) & SNAP_MASK;
        last_snapshot = tick.total_ops_snapshot;
        if (delta > DELTA_CAP) begin
            delta = DELTA_CAP;
        end

        // oldest sample leaves once the window is full
        if (history_fill >= WINDOW) begin
            rate_sum = rate_sum - 64'(rate_history[history_slot]);
        end
        rate_history[history_slot] = delta[DELTA_W-1:0];
        rate_sum = rate_sum + delta;
        history_slot = (history_slot + 1 >= WINDOW) ? 0 : history_slot + 1;
        if (history_fill < WINDOW) begin
            history_fill++;
        end

        fill = 64'(history_fill);
        sum  = rate_sum;
        act  = 64'(tick.active_count);

        // exact rational compares against the mean
        if (sum < fill) begin
            want = larger_of(act, IDLE_WORKERS);
        end else begin
            mean_ceil = (sum + fill - 64'd1) / fill;
            if (act * fill < sum) begin
                want = larger_of(scale_q8(act, up_factor), mean_ceil);
            end else if (64'd2 * act * fill > 64'd3 * sum) begin
                want = larger_of(scale_q8(act, down_factor), mean_ceil);
            end else begin
                want = act;
            end
        end

        if (want < 64'd1) begin
            want = 64'd1;
        end
        if (want > WORKER_CAP) begin
            want = WORKER_CAP;
        end

        res.target_count   = want[COUNT_W-1:0];
        res.target_changed = (want[COUNT_W-1:0] != held_target);
        res.spawn_count    = '0;
        if (res.target_changed) begin
            held_target = want[COUNT_W-1:0];
            if (act < want) begin
                res.spawn_count = COUNT_W'(want - act);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat got;
        t_out_beat want;

        if (!i_rst_n) begin
            up_factor     = UP_RESET;
            down_factor   = DOWN_RESET;
            last_snapshot = '0;
            rate_sum      = '0;
            history_fill  = 0;
            history_slot  = 0;
            held_target   = COUNT_W'(1);
            pending_targets.delete();
        end else begin
            // register writes, unknown indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCALE_UP: begin
                        up_factor = i_cfg_data;
                    end
                    CFG_SCALE_DOWN: begin
                        down_factor = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end

            // result beat against the oldest expected target
            if (i_out_ch.valid && i_out_ch.ready) begin
                got = i_out_ch.data;
                if (pending_targets.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: result beat with no tick pending: ", $realtime,
                                 "target %0d changed %0b spawn %0d",
                                 got.target_count, got.target_changed,
                                 got.spawn_count);
                    end
                end else begin
                    want = pending_targets.pop_front();
                    if (got.target_count !== want.target_count ||
                        got.target_changed !== want.target_changed ||
                        got.spawn_count !== want.spawn_count) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch: ", $realtime,
                                     "expected target %0d changed %0b spawn %0d, ",
                                     want.target_count, want.target_changed,
                                     want.spawn_count,
                                     "got target %0d changed %0b spawn %0d",
                                     got.target_count, got.target_changed,
                                     got.spawn_count);
                        end
                    end
                end
            end

            // tick beat taken in
            if (i_in_ch.valid && i_in_ch.ready) begin
                predict_target(i_in_ch.data, want);
                pending_targets.push_back(want);
            end
        end
        queued_count = pending_targets.size();
    end

endmodule

// ===== tb/worker_count_autoscaler_unit_tb.sv =====
module worker_count_autoscaler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wcas_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 50;

    // indexes past the last register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wcas_in_if  tick_ch ();
    wcas_out_if target_ch ();

    int               fail_count;
    int               waiting_results;
    int               cycles;
    int               burst_left;
    bit               hold_request;
    logic [SNAP_W-1:0] snapshot;

    worker_count_autoscaler_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (tick_ch),
        .o_out       (target_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    wcas_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_ch           (tick_ch),
        .i_out_ch          (target_ch),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (fail_count),
        .o_waiting_results (waiting_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run length guard
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL worker_count_autoscaler_unit");
        $finish;
    end

    // result side: random stalls, steady runs and the long hold-off
    initial begin
        int stall_left;
        int steady_left;
        int r;

        stall_left      = 0;
        steady_left     = 0;
        target_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                target_ch.ready <= 1'b0;
                stall_left--;
            end else if (hold_request) begin
                hold_request    = 1'b0;
                stall_left      = HOLD_CYCLES - 1;
                target_ch.ready <= 1'b0;
            end else if (steady_left > 0) begin
                target_ch.ready <= 1'b1;
                steady_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    target_ch.ready <= 1'b1;
                end else if (r < 75) begin
                    steady_left     = $urandom_range(20, 80);
                    target_ch.ready <= 1'b1;
                end else if (r < 96) begin
                    stall_left      = $urandom_range(0, 3);
                    target_ch.ready <= 1'b0;
                end else begin
                    stall_left      = $urandom_range(10, 40);
                    target_ch.ready <= 1'b0;
                end
            end
        end
    end

    // offer one tick beat after a random gap, return at the negedge after accept
    task automatic send_tick(input logic [SNAP_W-1:0] snap, input logic [COUNT_W-1:0] act);
        int gap;
        int r;

        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                gap = 0;
            end else if (r < 88) begin
                gap = $urandom_range(1, 3);
            end else if (r < 97) begin
                gap = $urandom_range(4, 12);
            end else begin
                gap = $urandom_range(20, 60);
            end
            if ($urandom_range(0, 29) == 0) begin
                burst_left = $urandom_range(10, 30);
            end
        end
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= {snap, act};
        do @(posedge i_clk); while (!tick_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // wait until every target is back and the block has gone quiet
    task automatic settle();
        while (waiting_results != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // one phase of random ticks under fixed factors
    task automatic run_phase(input logic [FACTOR_W-1:0] up, input logic [FACTOR_W-1:0] down,
                             input int ticks, input int rate_hi, input bit noisy,
                             input bit squeeze);
        int                r;
        int                act_hi;
        logic [SNAP_W-1:0] step;
        logic [COUNT_W-1:0] act;

        settle();
        write_reg(CFG_SCALE_UP, up);
        write_reg(CFG_SCALE_DOWN, down);
        if (squeeze) begin
            hold_request = 1'b1;
        end
        act_hi = rate_hi + rate_hi / 2;
        if (act_hi > 65535) begin
            act_hi = 65535;
        end
        repeat (ticks) begin
            // counter advance, with jumps and huge deltas when noisy
            r    = $urandom_range(0, 99);
            step = SNAP_W'($urandom_range(0, rate_hi));
            if (r < 10) begin
                step = '0;
            end
            if (noisy && r >= 98) begin
                snapshot = SNAP_W'({$urandom, $urandom});
                step     = '0;
            end else if (noisy && r >= 96) begin
                step = SNAP_W'($urandom);
            end else if (noisy && r >= 94) begin
                step = SNAP_W'({$urandom, $urandom});
            end
            snapshot = snapshot + step;

            // active count mostly around the mean, sometimes anywhere
            r = $urandom_range(0, 99);
            if (r < 70) begin
                act = COUNT_W'($urandom_range(0, act_hi));
            end else if (r < 80) begin
                act = COUNT_W'($urandom_range(0, 12));
            end else if (r < 95) begin
                act = COUNT_W'($urandom);
            end else if (r < 97) begin
                act = '0;
            end else begin
                act = '1;
            end
            send_tick(snapshot, act);
        end
        tick_ch.valid <= 1'b0;
    endtask

    initial begin
        int rates [4];

        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        tick_ch.valid = 1'b0;
        tick_ch.data  = '0;
        hold_request  = 1'b0;
        burst_left    = 0;
        snapshot      = '0;
        rates         = '{1, 40, 3000, 60000};

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed ticks under reset factors
        send_tick(48'd0, 16'd0);                 // idle mean, floor of ten
        send_tick(48'd0, 16'hFFFF);
        send_tick(48'd0, 16'd10);
        send_tick(48'd400, 16'd0);               // scale up from nothing
        send_tick(48'd800, 16'd50);
        send_tick(48'd1200, 16'd1000);           // scale down
        send_tick(48'd1600, 16'd200);
        send_tick(48'd2000, 16'd250);            // inside the hold band
        send_tick(48'd2400, 16'd400);            // exactly 1.5 times the mean
        send_tick(48'd2800, 16'd280);            // exactly the mean
        send_tick(48'd2800, 16'd1);              // no progress
        send_tick(48'hFFFF_FFFF_FFFF, 16'hFFFF); // huge delta saturates
        send_tick(48'h0000_0000_0010, 16'd0);    // counter wraps
        send_tick(48'h0001_0000_000F, 16'd1);    // delta right at the cap
        send_tick(48'h0002_0000_000F, 16'd2);    // delta one past the cap
        send_tick(48'h0002_0000_000F, 16'hFFFF);
        tick_ch.valid <= 1'b0;
        snapshot = 48'h0002_0000_000F;

        // writes to unused indexes must not disturb the factors
        settle();
        write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));

        run_phase(16'd512, 16'd128, 80, 2000, 1'b0, 1'b1);
        run_phase(16'd0, 16'd0, 70, 500, 1'b0, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 70, 3000, 1'b0, 1'b0);
        run_phase(16'd256, 16'd256, 60, 1, 1'b0, 1'b0);
        for (int k = 0; k < 4; k++) begin
            run_phase(FACTOR_W'($urandom), FACTOR_W'($urandom_range(0, 512)), 50,
                      rates[k], k == 2, k == 1);
        end
        run_phase(16'd384, 16'd192, 60, 60000, 1'b1, 1'b1);
        settle();

        if (fail_count == 0) begin
            $display("PASS worker_count_autoscaler_unit");
        end else begin
            $display("FAIL worker_count_autoscaler_unit");
        end
        $finish;
    end

endmodule
